// ===== sv/bltd_pkg.sv =====
package bltd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned MaxRes = 3;

  // code point map ranges
  localparam logic [ByteW-1:0] PrintLo  = 8'd33;
  localparam logic [ByteW-1:0] PrintHi  = 8'd126;
  localparam logic [ByteW-1:0] Lat1Lo   = 8'hA1;
  localparam logic [ByteW-1:0] Lat1Hi   = 8'hAC;
  localparam logic [ByteW-1:0] Lat2Lo   = 8'hAE;
  localparam logic [6:0]       ShiftCnt = 7'd68;
  localparam logic [6:0]       CtlLast  = 7'd32;
  localparam logic [6:0]       HighLast = 7'd66;
  localparam logic [ByteW-1:0] HighOff  = 8'd94;
  localparam logic [ByteW-1:0] SoftHyph = 8'd173;

  // lead byte prefixes
  localparam logic [2:0] Lead2Pfx = 3'h6;
  localparam logic [3:0] Lead3Pfx = 4'hE;
  localparam logic [4:0] Lead4Pfx = 5'h1E;

  localparam logic [2:0] Len1 = 3'd1;
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;

  // results of one input item
  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [1:0]                   count;
  } grp_t;

endpackage

// ===== sv/bltd_in_if.sv =====
interface bltd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       token_end;

  modport source (output valid, output text_byte, output token_end, input ready);
  modport sink (input valid, input text_byte, input token_end, output ready);
endinterface

// ===== sv/bltd_out_if.sv =====
interface bltd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       run_last;

  modport source (output valid, output raw_byte, output run_last, input ready);
  modport sink (input valid, input raw_byte, input run_last, output ready);
endinterface

// ===== sv/bltd_assemble.sv =====
module bltd_assemble (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic              token_end,
  output bltd_pkg::grp_t    grp
);
  import bltd_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [ByteW-1:0] b;
  } map_t;

  function automatic logic [2:0] lead_len(input logic [ByteW-1:0] c);
    logic [2:0] len;
    len = Len1;
    if (c[7:5] == Lead2Pfx) len = Len2;
    else if (c[7:4] == Lead3Pfx) len = Len3;
    else if (c[7:3] == Lead4Pfx) len = Len4;
    return len;
  endfunction

  function automatic map_t cp_map(input logic [CpW-1:0] cp);
    map_t       m;
    logic [6:0] n;
    m.ok = 1'b0;
    m.b  = cp[ByteW-1:0];
    n    = cp[6:0];
    if (cp[CpW-1:ByteW] == '0) begin
      m.ok = (m.b >= PrintLo && m.b <= PrintHi) || (m.b >= Lat1Lo && m.b <= Lat1Hi) ||
             (m.b >= Lat2Lo);
    end else if (cp[CpW-1:ByteW+1] == '0 && cp[ByteW] && !cp[7] && n < ShiftCnt) begin
      m.ok = 1'b1;
      if (n <= CtlLast) m.b = {1'b0, n};
      else if (n <= HighLast) m.b = {1'b0, n} + HighOff;
      else m.b = SoftHyph;
    end
    return m;
  endfunction

  logic [2:0][ByteW-1:0] pend;
  logic [1:0]            pcnt;
  logic [2:0]            need_q;

  logic [3:0][ByteW-1:0] run_b;
  logic [2:0]            cnt_new;
  logic [2:0]            need;
  logic                  emit;
  logic                  complete;
  logic                  pair;
  logic                  has1;
  logic                  has2;
  logic [CpW-1:0]        cp0;
  logic [CpW-1:0]        cp1;
  map_t                  m0;
  map_t                  m1;
  map_t                  m2;

  always_comb begin
    run_b = '0;
    for (int i = 0; i < 3; i++) begin
      run_b[i] = pend[i];
    end
    run_b[pcnt] = text_byte;
    cnt_new  = {1'b0, pcnt} + 3'd1;
    need     = (pcnt == 2'd0) ? lead_len(text_byte) : need_q;
    complete = (cnt_new >= need);
    emit     = token_end || complete;

    unique case (need)
      Len2:    cp0 = {10'd0, run_b[0][4:0], run_b[1][5:0]};
      Len3:    cp0 = {5'd0, run_b[0][3:0], run_b[1][5:0], run_b[2][5:0]};
      Len4:    cp0 = {run_b[0][2:0], run_b[1][5:0], run_b[2][5:0], run_b[3][5:0]};
      default: cp0 = {13'd0, run_b[0]};
    endcase
    // a cut sequence: the lead stands alone
    if (!complete) cp0 = {13'd0, run_b[0]};

    pair = !complete && (cnt_new == 3'd3) && (lead_len(run_b[1]) == Len2);
    has1 = !complete && (cnt_new >= 3'd2);
    has2 = !complete && (cnt_new == 3'd3) && !pair;
    cp1  = pair ? {10'd0, run_b[1][4:0], run_b[2][5:0]} : {13'd0, run_b[1]};

    m0 = cp_map(cp0);
    m1 = cp_map(cp1);
    m2 = cp_map({13'd0, run_b[2]});

    grp = '0;
    if (emit) begin
      if (m0.ok) begin
        grp.bytes[grp.count] = m0.b;
        grp.count = grp.count + 2'd1;
      end
      if (has1 && m1.ok) begin
        grp.bytes[grp.count] = m1.b;
        grp.count = grp.count + 2'd1;
      end
      if (has2 && m2.ok) begin
        grp.bytes[grp.count] = m2.b;
        grp.count = grp.count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt   <= '0;
      need_q <= '0;
    end else if (accept) begin
      if (emit) begin
        pcnt   <= '0;
        need_q <= '0;
      end else begin
        pcnt   <= cnt_new[1:0];
        need_q <= need;
      end
    end
  end

  // hold the unfinished sequence
  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      pend <= run_b[2:0];
    end
  end

endmodule

// ===== sv/bltd_expand.sv =====
module bltd_expand (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bltd_pkg::grp_t grp_in,
  output logic           free,
  output logic           valid,
  input  logic           ready,
  output logic [7:0]     raw_byte,
  output logic           run_last
);
  import bltd_pkg::*;

  grp_t       grp;
  logic [1:0] idx;
  logic       take;

  assign valid    = (grp.count != 2'd0);
  assign raw_byte = grp.bytes[idx];
  assign run_last = (idx == grp.count - 2'd1);
  assign take     = valid && ready;
  assign free     = !valid || (take && run_last);

  always_ff @(posedge clk) begin
    if (load) begin
      grp.bytes <= grp_in.bytes;
    end
    if (rst) begin
      grp.count <= '0;
      idx       <= '0;
    end else if (load) begin
      grp.count <= grp_in.count;
      idx       <= '0;
    end else if (take) begin
      // advance within the group, drop it after the last transaction
      if (run_last) grp.count <= '0;
      else idx <= idx + 2'd1;
    end
  end

endmodule

// ===== sv/byte_level_token_text_decoder_core.sv =====
// Byte-level token text decoder.
// text_in carries the UTF-8 text of one vocabulary token, one byte per
// transaction, with token_end set on the token's last byte. byte_out carries
// the decoded raw bytes; run_last marks the last byte caused by one input
// byte. An input byte causes zero to three output bytes.
// The results of an input byte appear on byte_out in the cycle after it is
// accepted. Throughput: one input byte per cycle while each byte gives at
// most one result and the receiver does not stall; a byte that gives more
// results keeps text_in from taking the next byte until the single result
// register has drained them, one byte per cycle while the receiver is ready.
// A multi-byte sequence is buffered until complete or until token_end; bytes
// that complete nothing produce no output.
// Reset (rst, synchronous) clears the pending sequence and the result
// register; text_in is ready in the first cycle after reset.
// When the receiver stalls, byte_out holds its byte and text_in is held off
// until the last result of the current group has gone out.
module byte_level_token_text_decoder_core (
  input  logic      clk,
  input  logic      rst,
  bltd_in_if.sink   text_in,
  bltd_out_if.source byte_out
);
  import bltd_pkg::*;

  grp_t grp;
  logic free;
  logic accept;

  assign text_in.ready = free;
  assign accept        = text_in.valid && free;

  bltd_assemble u_assemble (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_in.text_byte),
    .token_end (text_in.token_end),
    .grp       (grp)
  );

  bltd_expand u_expand (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .grp_in   (grp),
    .free     (free),
    .valid    (byte_out.valid),
    .ready    (byte_out.ready),
    .raw_byte (byte_out.raw_byte),
    .run_last (byte_out.run_last)
  );

endmodule

// ===== sv/bltd_checker.sv =====
module bltd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] raw_byte,
  input logic       run_last
);

  // nothing goes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(raw_byte) && $stable(run_last))
    else $error("stalled result changed");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  a_group_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_last |-> !in_ready)
    else $error("input accepted while a result group is unfinished");

endmodule

bind byte_level_token_text_decoder_core bltd_checker u_bltd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (text_in.ready),
  .out_valid (byte_out.valid),
  .out_ready (byte_out.ready),
  .raw_byte  (byte_out.raw_byte),
  .run_last  (byte_out.run_last)
);

// ===== tb/tb_byte_level_token_text_decoder_core.sv =====
module tb_byte_level_token_text_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bltd_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] raw;
    logic             last;
  } raw_out_t;

  // one directed transaction; known rows carry their results typed in
  typedef struct packed {
    logic [ByteW-1:0] text;
    logic             last;
    logic             known;
    logic [1:0]       n;
    logic [ByteW-1:0] e0;
    logic [ByteW-1:0] e1;
    logic [ByteW-1:0] e2;
  } dir_row_t;

  localparam int DirN     = 26;
  localparam int LongHold = 60;

  localparam dir_row_t DirRows [DirN] = '{
    '{8'h41, 1'b1, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
    '{8'h00, 1'b1, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00},
    '{8'h7E, 1'b0, 1'b1, 2'd1, 8'h7E, 8'h00, 8'h00},
    '{8'h7F, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hA1, 1'b0, 1'b1, 2'd1, 8'hA1, 8'h00, 8'h00},
    '{8'hAD, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hAC, 1'b0, 1'b1, 2'd1, 8'hAC, 8'h00, 8'h00},
    '{8'hAE, 1'b1, 1'b1, 2'd1, 8'hAE, 8'h00, 8'h00},
    '{8'hC4, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00},
    '{8'hC5, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h83, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hE0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h84, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h81, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h81, 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hE2, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h41, 1'b1, 1'b1, 2'd2, 8'hE2, 8'h41, 8'h00},
    '{8'hF0, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h41, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h42, 1'b1, 1'b1, 2'd3, 8'hF0, 8'h41, 8'h42},
    '{8'hC3, 1'b1, 1'b1, 2'd1, 8'hC3, 8'h00, 8'h00}
  };

  logic clk = 1'b0;
  logic rst;

  bltd_in_if  text_in();
  bltd_out_if byte_out();

  byte_level_token_text_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .byte_out (byte_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder state mirror
  logic [ByteW-1:0] pend_bytes [3];
  int               pend_cnt = 0;
  int               need_len = 0;

  raw_out_t decoded_q [$];
  raw_out_t grp_q [$];

  int   err_cnt     = 0;
  int   rand_items  = 0;
  int   dir_items   = 0;
  int   raw_checked = 0;
  int   multi_grps  = 0;
  logic src_idle_en = 1'b0;
  logic snk_idle_en = 1'b0;
  logic hold_req    = 1'b0;

  function automatic int seq_len(logic [ByteW-1:0] c);
    if (c[7] == 1'b0) return 1;
    if (c[7:5] == Lead2Pfx) return 2;
    if (c[7:4] == Lead3Pfx) return 3;
    if (c[7:3] == Lead4Pfx) return 4;
    return 1;
  endfunction

  // -1 when the code point lies outside the byte map
  function automatic int cp_to_raw(logic [CpW-1:0] cp);
    int n;
    if ((cp >= PrintLo && cp <= PrintHi) || (cp >= Lat1Lo && cp <= Lat1Hi) ||
        (cp >= Lat2Lo && cp <= 255)) begin
      return int'(cp);
    end
    if (cp >= 256 && cp < 256 + ShiftCnt) begin
      n = int'(cp) - 256;
      if (n <= CtlLast) return n;
      if (n <= HighLast) return n + HighOff;
      return SoftHyph;
    end
    return -1;
  endfunction

  function automatic void decode_text_byte(logic [ByteW-1:0] c, logic fin);
    logic [ByteW-1:0] run [4];
    logic [CpW-1:0]   cp;
    int cnt, need, i, len, v;
    cnt  = pend_cnt;
    need = need_len;
    for (i = 0; i < cnt; i++) run[i] = pend_bytes[i];
    if (cnt == 0) need = seq_len(c);
    run[cnt] = c;
    cnt++;
    grp_q.delete();
    if (!fin && cnt < need) begin
      for (i = 0; i < cnt; i++) pend_bytes[i] = run[i];
      pend_cnt = cnt;
      need_len = need;
      return;
    end
    // a lead that runs past the end stands alone; decode the rest afresh
    i = 0;
    while (i < cnt) begin
      len = seq_len(run[i]);
      cp  = CpW'(run[i]);
      if (len > 1 && i + len - 1 < cnt) begin
        case (len)
          2: cp = CpW'({run[i][4:0], run[i+1][5:0]});
          3: cp = CpW'({run[i][3:0], run[i+1][5:0], run[i+2][5:0]});
          default: cp = CpW'({run[i][2:0], run[i+1][5:0], run[i+2][5:0], run[i+3][5:0]});
        endcase
      end else begin
        len = 1;
      end
      i += len;
      v = cp_to_raw(cp);
      if (v >= 0) grp_q.insert(grp_q.size(), '{raw: ByteW'(v), last: 1'b0});
    end
    if (grp_q.size() > 0) grp_q[grp_q.size()-1].last = 1'b1;
    for (i = 0; i < 3; i++) pend_bytes[i] = '0;
    pend_cnt = 0;
    need_len = 0;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // enter and leave at a falling edge
  task automatic push_byte(dir_row_t row);
    int k;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      text_in.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    text_in.valid     <= 1'b1;
    text_in.text_byte <= row.text;
    text_in.token_end <= row.last;
    do @(posedge clk); while (!text_in.ready);
    decode_text_byte(row.text, row.last);
    if (row.known) begin
      grp_q.delete();
      for (k = 0; k < int'(row.n); k++) begin
        grp_q.insert(grp_q.size(),
                     '{raw: (k == 0) ? row.e0 : (k == 1) ? row.e1 : row.e2,
                       last: (k == int'(row.n) - 1)});
      end
    end
    if (grp_q.size() > 1) multi_grps++;
    for (k = 0; k < grp_q.size(); k++) decoded_q.insert(decoded_q.size(), grp_q[k]);
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] rand_cont();
    if ($urandom_range(0, 5) == 0) return ByteW'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic send_random_token();
    logic [ByteW-1:0] tok [$];
    logic [8:0]       cp9;
    dir_row_t         row;
    int               nch, cut, j;
    nch = $urandom_range(1, 4);
    repeat (nch) begin
      case ($urandom_range(0, 9))
        0, 1, 2: tok.insert(tok.size(), ByteW'($urandom_range(0, 127)));
        3, 4: begin
          cp9 = 9'(256 + $urandom_range(0, 67));
          tok.insert(tok.size(), {3'b110, 5'(cp9 >> 6)});
          tok.insert(tok.size(), {2'b10, cp9[5:0]});
        end
        5: begin
          tok.insert(tok.size(), {3'b110, 5'($urandom)});
          tok.insert(tok.size(), rand_cont());
        end
        6: begin
          tok.insert(tok.size(), {4'b1110, 4'($urandom)});
          tok.insert(tok.size(), rand_cont());
          tok.insert(tok.size(), rand_cont());
        end
        7: begin
          tok.insert(tok.size(), {5'b11110, 3'($urandom)});
          tok.insert(tok.size(), rand_cont());
          tok.insert(tok.size(), rand_cont());
          tok.insert(tok.size(), rand_cont());
        end
        8: tok.insert(tok.size(), ByteW'($urandom));
        default: begin
          cp9 = 9'($urandom_range(128, 255));
          tok.insert(tok.size(), {3'b110, 5'(cp9 >> 6)});
          tok.insert(tok.size(), {2'b10, cp9[5:0]});
        end
      endcase
    end
    // cut the token short now and then, often inside a sequence
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, tok.size());
      while (tok.size() > cut) void'(tok.pop_back());
    end
    row = '0;
    for (j = 0; j < tok.size(); j++) begin
      row.text = tok[j];
      row.last = (j == tok.size() - 1);
      push_byte(row);
      rand_items++;
    end
  endtask

  always @(posedge clk) begin
    raw_out_t want;
    if (!rst && byte_out.valid && byte_out.ready) begin
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected raw_byte %02h run_last %0b",
                         byte_out.raw_byte, byte_out.run_last));
      end else begin
        want = decoded_q.pop_front();
        raw_checked++;
        if (byte_out.raw_byte !== want.raw)
          report($sformatf("raw_byte got %02h want %02h", byte_out.raw_byte, want.raw));
        if (byte_out.run_last !== want.last)
          report($sformatf("run_last got %0b want %0b (raw_byte %02h)",
                           byte_out.run_last, want.last, want.raw));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    byte_out.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        byte_out.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_req = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        byte_out.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        byte_out.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #500_000;
    $display("timeout with %0d results outstanding", decoded_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst               <= 1'b1;
    text_in.valid     <= 1'b0;
    text_in.text_byte <= '0;
    text_in.token_end <= 1'b0;
    for (int i = 0; i < 3; i++) pend_bytes[i] = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    for (int r = 0; r < DirN; r++) begin
      push_byte(DirRows[r]);
      dir_items++;
    end

    // drain fully before the random part
    text_in.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    @(negedge clk);

    // keep offering while the receiver holds off
    hold_req = 1'b1;
    while (rand_items < 75) send_random_token();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    while (rand_items < 100) send_random_token();

    text_in.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Fed %0d text bytes (%0d directed, %0d random tokens' bytes), checked %0d raw bytes",
             dir_items + rand_items, dir_items, rand_items, raw_checked);
    $display("  %0d bytes gave several results; covered map edges, cut and multi-byte tokens",
             multi_grps);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
